// File: design/tzc_pkg.sv
// tzc_pkg: shared types, codes and constants of the trajectory zone classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package tzc_pkg;

	localparam int COORD_W       = 16;
	localparam int FRAME_W       = 32;
	localparam int KIND_W        = 2;
	localparam int NUM_RECTS     = 4;
	localparam int NUM_CLASSES   = 7;
	localparam int OUT_CNT_W     = 10;
	localparam int COUNT_W_DEF   = 10;

	localparam int NUM_REGS      = 2 * NUM_RECTS;
	localparam int REG_W         = 64;
	localparam int REG_IDX_W     = $clog2(NUM_REGS);
	localparam int REG_SEL_LSB   = 3;
	localparam int ADDR_W        = REG_IDX_W + REG_SEL_LSB;

	localparam int IN_TDATA_W    = 4 * COORD_W + FRAME_W;

	localparam logic [REG_W-1:0] RECT_RESET = 64'h0000_0000_FFFF_FFFF;

	localparam logic [KIND_W-1:0] KIND_TRAJ      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRAJ_END  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FRAME_END = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] y2;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x1;
	} rect_t;

	typedef enum logic [1:0] {
		LOC_ENTRANCE = 2'd0,
		LOC_BORDER   = 2'd1,
		LOC_NOWHERE  = 2'd2
	} loc_t;

	typedef enum logic [2:0] {
		CLS_IN        = 3'd0,
		CLS_OUT       = 3'd1,
		CLS_FLYBY_IN  = 3'd2,
		CLS_FLYBY_OUT = 3'd3,
		CLS_LOST_IN   = 3'd4,
		CLS_LOST_OUT  = 3'd5,
		CLS_LOST      = 3'd6
	} cls_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [COORD_W-1:0] end_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_x;
		logic [KIND_W-1:0]  kind;
	} item_t;

	// one processed item handed to the statistics stage
	typedef struct packed {
		logic               go;
		logic [KIND_W-1:0]  kind;
		loc_t               first;
		loc_t               last;
		logic [FRAME_W-1:0] frame;
	} stats_req_t;

	typedef struct packed {
		logic [1:0]                              pad;
		logic [NUM_CLASSES-1:0][OUT_CNT_W-1:0]   counts;
		logic [FRAME_W-1:0]                      frame;
	} report_t;

	localparam int OUT_TDATA_W = $bits(report_t);

endpackage

`default_nettype wire

// File: design/tzc_regs.sv
// tzc_regs: APB register file holding the four entrance and four border rectangles.
// Depends on tzc_pkg.
`default_nettype none

module tzc_regs import tzc_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ADDR_W-1:0]           paddr,
	input  wire logic [REG_W-1:0]            pwdata,
	output logic      [REG_W-1:0]            prdata,
	output logic                             pready,
	output rect_t     [NUM_RECTS-1:0]        entrance,
	output rect_t     [NUM_RECTS-1:0]        border
);

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic [REG_IDX_W-1:0] sel;

	assign pready = 1'b1;
	assign sel    = paddr[ADDR_W-1:REG_SEL_LSB];
	assign prdata = regs_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= RECT_RESET;
			end
		end else if (psel && penable && pwrite && pready) begin
			regs_q[sel] <= pwdata;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_RECTS; i++) begin
			entrance[i] = rect_t'(regs_q[i]);
			border[i]   = rect_t'(regs_q[NUM_RECTS + i]);
		end
	end

endmodule

`default_nettype wire

// File: design/tzc_locate.sv
// tzc_locate: places one point in an entrance rectangle, a border rectangle or nowhere.
// Depends on tzc_pkg.
`default_nettype none

module tzc_locate import tzc_pkg::*; (
	input  wire rect_t [NUM_RECTS-1:0] entrance,
	input  wire rect_t [NUM_RECTS-1:0] border,
	input  wire logic [COORD_W-1:0] x,
	input  wire logic [COORD_W-1:0] y,
	output loc_t                    loc
);

	logic [NUM_RECTS-1:0] in_ent;
	logic [NUM_RECTS-1:0] in_brd;

	always_comb begin
		for (int i = 0; i < NUM_RECTS; i++) begin
			in_ent[i] = (x >= entrance[i].x1) && (x <= entrance[i].x2) &&
			            (y >= entrance[i].y1) && (y <= entrance[i].y2);
			in_brd[i] = (x >= border[i].x1) && (x <= border[i].x2) &&
			            (y >= border[i].y1) && (y <= border[i].y2);
		end
		if (|in_ent) begin
			loc = LOC_ENTRANCE;
		end else if (|in_brd) begin
			loc = LOC_BORDER;
		end else begin
			loc = LOC_NOWHERE;
		end
	end

endmodule

`default_nettype wire

// File: design/tzc_stats.sv
// tzc_stats: class decode, saturating per-class counters and the report output register.
// Depends on tzc_pkg.
`default_nettype none

module tzc_stats import tzc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_W_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire stats_req_t             req,
	output logic                        out_free,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] cnt_q    [NUM_CLASSES];
	logic [COUNT_WIDTH-1:0] cnt_next [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] inc;
	cls_t                   cls;
	logic                   hit;
	logic                   emit;
	logic                   out_valid_q;
	report_t                report_q;
	report_t                report_d;

	assign hit  = req.go && (req.kind == KIND_TRAJ || req.kind == KIND_TRAJ_END);
	assign emit = req.go && (req.kind == KIND_TRAJ_END || req.kind == KIND_FRAME_END);

	always_comb begin
		case (req.last)
			LOC_ENTRANCE: begin
				case (req.first)
					LOC_BORDER:   cls = CLS_IN;
					LOC_ENTRANCE: cls = CLS_FLYBY_IN;
					default:      cls = CLS_LOST_IN;
				endcase
			end
			LOC_BORDER: begin
				case (req.first)
					LOC_ENTRANCE: cls = CLS_OUT;
					LOC_BORDER:   cls = CLS_FLYBY_OUT;
					default:      cls = CLS_LOST_OUT;
				endcase
			end
			default: cls = CLS_LOST;
		endcase
	end

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cnt
		assign inc[g]      = hit && (cls == cls_t'(3'(g))) && (cnt_q[g] != CNT_MAX);
		assign cnt_next[g] = cnt_q[g] + COUNT_WIDTH'(inc[g]);
		assign report_d.counts[g] = OUT_CNT_W'(cnt_next[g]);
	end

	assign report_d.pad   = '0;
	assign report_d.frame = req.frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (emit) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (hit) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				cnt_q[i] <= cnt_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			report_q <= report_d;
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = report_q;

	// a report clears every counter
	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0) &&
		         (cnt_q[3] == '0) && (cnt_q[4] == '0) && (cnt_q[5] == '0) &&
		         (cnt_q[6] == '0))
		else $error("counters not cleared after report");

	// counters move only with a processed trajectory or report
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!req.go |=> $stable(cnt_q[0]) && $stable(cnt_q[1]) && $stable(cnt_q[2]) &&
		            $stable(cnt_q[3]) && $stable(cnt_q[4]) && $stable(cnt_q[5]) &&
		            $stable(cnt_q[6]))
		else $error("counter changed without a processed item");

	// a plain trajectory never produces a report
	a_no_report_on_traj: assert property (@(posedge clk) disable iff (!arst_n)
		(req.go && req.kind == KIND_TRAJ) |=> !$rose(m_axis_tvalid))
		else $error("report raised by a plain trajectory");

	// at most one class counts per trajectory
	a_one_class: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(inc))
		else $error("more than one class counted");

endmodule

`default_nettype wire

// File: design/trajectory_zone_classifier_top.sv
// trajectory_zone_classifier_top: input register, point location and statistics.
// Depends on tzc_pkg, tzc_regs, tzc_locate, tzc_stats.
//
// Accepts one word per clock; only a trajectory-end or frame-end word is held, in
// the input register, while the previous report has not been taken, and plain
// trajectory words flow on while a report waits. A word's two points are located
// against the rectangles from that register; when it goes on, a trajectory or
// trajectory-end word bumps its class counter and a trajectory-end or frame-end word
// loads the report register in that same cycle. Rectangles are written over APB at
// byte address 8*i (entrance 0..3, then border 0..3) while the stream is idle.
`default_nettype none

module trajectory_zone_classifier_top import tzc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_W_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [REG_W-1:0]        pwdata,
	output logic      [REG_W-1:0]        prdata,
	output logic                         pready,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	// start_x, start_y, end_x, end_y, frame_number
	input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// kind
	input  wire logic [KIND_W-1:0]       s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	// report_frame, count_in, count_out, count_flyby_in, count_flyby_out,
	// count_lost_in, count_lost_out, count_lost, 2 zero bits
	output logic [OUT_TDATA_W-1:0]       m_axis_tdata
);

	rect_t [NUM_RECTS-1:0] entrance;
	rect_t [NUM_RECTS-1:0] border;
	item_t                 item_s1;
	logic                  valid_s1;
	logic                  need_out;
	logic                  out_free;
	logic                  go;
	loc_t                  loc_first;
	loc_t                  loc_last;
	stats_req_t            req;

	tzc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.entrance (entrance),
		.border   (border)
	);

	assign need_out      = (item_s1.kind == KIND_TRAJ_END) || (item_s1.kind == KIND_FRAME_END);
	assign go            = valid_s1 && (!need_out || out_free);
	assign s_axis_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'({s_axis_tdata, s_axis_tuser});
		end
	end

	tzc_locate u_loc_first (
		.entrance (entrance),
		.border   (border),
		.x        (item_s1.start_x),
		.y        (item_s1.start_y),
		.loc      (loc_first)
	);

	tzc_locate u_loc_last (
		.entrance (entrance),
		.border   (border),
		.x        (item_s1.end_x),
		.y        (item_s1.end_y),
		.loc      (loc_last)
	);

	assign req.go    = go;
	assign req.kind  = item_s1.kind;
	assign req.first = loc_first;
	assign req.last  = loc_last;
	assign req.frame = item_s1.frame;

	tzc_stats #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_stats (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire
